[hw/rtl/rclmp_pkg.sv]
// Shared constants and types for the reverse Collatz layer min-plus engine.
`default_nettype none

package rclmp_pkg;

    localparam int DEPTH_DEF     = 65536;
    localparam int MAX_SHIFT_DEF = 100;
    localparam int COST_W        = 16;

    // Store entry that holds no path.
    localparam logic [COST_W-1:0] COST_NONE   = 16'hFFFF;
    localparam logic [15:0]       LIMIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [15:0]       layer_number;
        logic              found;
        logic [COST_W-1:0] min_cost;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/rclmp_bank.sv]
// One layer store: single write port, single registered read port.
`default_nettype none

module rclmp_bank import rclmp_pkg::*; #(
    parameter  int DEPTH = DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [COST_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [COST_W-1:0] o_rdata
);

    logic [COST_W-1:0] mem [DEPTH];
    logic [COST_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/rclmp_seq.sv]
// Sequencer and shared move unit: clears the next layer, sweeps the current one.
`default_nettype none

module rclmp_seq import rclmp_pkg::*; #(
    parameter  int STORE_DEPTH = DEPTH_DEF,
    parameter  int MAX_SHIFT   = MAX_SHIFT_DEF,
    localparam int AW          = $clog2(STORE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_restart,
    input  wire logic [15:0]       i_value_limit,
    output logic                   o_busy,
    output logic                   o_bank_sel,
    output logic      [AW-1:0]     o_cur_raddr,
    input  wire logic [COST_W-1:0] i_cur_rdata,
    output logic      [AW-1:0]     o_nxt_raddr,
    output logic                   o_nxt_we,
    output logic      [AW-1:0]     o_nxt_waddr,
    output logic      [COST_W-1:0] o_nxt_wdata,
    input  wire logic [COST_W-1:0] i_nxt_rdata,
    output logic                   o_res_valid,
    output t_result                o_res
);

    localparam int TW = AW + 4;
    localparam int BW = AW + 2;
    localparam int KW = $clog2(MAX_SHIFT + 3);
    localparam int CW = (AW > 16) ? AW : 16;
    localparam int SW = COST_W + 1;

    localparam logic [CW-1:0] LIM_CAP   = CW'(STORE_DEPTH - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
    localparam logic [KW-1:0] K_MAX     = KW'(MAX_SHIFT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RDCUR,
        S_EVAL,
        S_MOVE,
        S_UPD,
        S_DONE
    } t_state;

    function automatic logic [1:0] f_mod3_of9(input logic [3:0] v);
        logic [1:0] res;
        case (v)
            4'd0, 4'd3, 4'd6: res = 2'd0;
            4'd1, 4'd4, 4'd7: res = 2'd1;
            4'd2, 4'd5, 4'd8: res = 2'd2;
            default:          res = 2'd0;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] f_div3_of9(input logic [3:0] v);
        logic [1:0] res;
        case (v)
            4'd0, 4'd1, 4'd2: res = 2'd0;
            4'd3, 4'd4, 4'd5: res = 2'd1;
            4'd6, 4'd7, 4'd8: res = 2'd2;
            default:          res = 2'd0;
        endcase
        return res;
    endfunction

    // residue of a sum no larger than 8
    function automatic logic [1:0] f_mod3_small(input logic [3:0] s);
        logic [3:0] res;
        if (s >= 4'd6) begin
            res = s - 4'd6;
        end else if (s >= 4'd3) begin
            res = s - 4'd3;
        end else begin
            res = s;
        end
        return res[1:0];
    endfunction

    t_state              r_state;
    logic [AW-1:0]       r_lim;
    logic [BW-1:0]       r_bound;
    logic [AW-1:0]       r_clr;
    logic [AW-1:0]       r_x;
    logic [3:0]          r_x9;      // x mod 9
    logic [AW-1:0]       r_q;       // x div 3
    logic [COST_W-1:0]   r_c;
    logic [KW-1:0]       r_k;
    logic [TW-1:0]       r_t;       // 2^k * x
    logic [AW-1:0]       r_y;       // (t - 1) div 3
    logic [1:0]          r_r;       // (t - 1) mod 3, fixed per x
    logic [1:0]          r_ym;      // y mod 3
    logic [COST_W-1:0]   r_one;
    logic [15:0]         r_layer;
    logic                r_bank_sel;
    logic                r_layer0;
    logic                r_res_valid;
    t_result             r_res;

    logic [CW-1:0]       lim_ext;
    logic [AW-1:0]       lim_cl;
    logic [COST_W-1:0]   cur_c;
    logic [1:0]          m;
    logic [1:0]          q3;
    logic                x_last;
    logic                move_end;
    logic [SW-1:0]       tot;
    logic                upd_ok;
    logic [AW-1:0]       y_step;
    logic [1:0]          ym_step;
    logic [KW-1:0]       k0;
    logic [TW-1:0]       t0;
    logic [AW-1:0]       y0;
    logic [1:0]          r0;
    logic [1:0]          ym0;
    logic [15:0]         layer_inc;

    assign lim_ext = CW'(i_value_limit);
    assign lim_cl  = (lim_ext > LIM_CAP) ? AW'(LIM_CAP) : AW'(lim_ext);

    // layer zero is implied by a flag, so the current store needs no fill
    assign cur_c = r_layer0 ? ((r_x == AW'(1)) ? '0 : COST_NONE) : i_cur_rdata;

    assign m        = f_mod3_of9(r_x9);
    assign q3       = f_div3_of9(r_x9);
    assign x_last   = (r_x == r_lim);
    assign move_end = (r_t > TW'(r_bound)) || (r_k > K_MAX);
    assign tot      = {1'b0, r_c} + SW'(r_k);
    assign upd_ok   = (tot < {1'b0, COST_NONE}) && (tot < {1'b0, i_nxt_rdata});
    assign y_step   = (r_y << 2) + AW'(r_r) + AW'(1);
    assign ym_step  = f_mod3_small(4'(r_ym) + 4'(r_r) + 4'd1);

    always_comb begin
        case (m)
            2'd1: begin
                k0  = '0;
                t0  = TW'(r_x);
                y0  = r_q;
                r0  = 2'd0;
                ym0 = q3;
            end
            2'd2: begin
                k0  = KW'(1);
                t0  = TW'(r_x) << 1;
                y0  = (r_q << 1) + AW'(1);
                r0  = 2'd0;
                ym0 = f_mod3_small({1'b0, q3, 1'b0} + 4'd1);
            end
            default: begin
                k0  = KW'(1);
                t0  = TW'(r_x) << 1;
                y0  = (r_q << 1) - AW'(1);
                r0  = 2'd2;
                ym0 = f_mod3_small({1'b0, q3, 1'b0} + 4'd2);
            end
        endcase
    end

    assign layer_inc = (&r_layer) ? r_layer : r_layer + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank_sel  <= 1'b0;
            r_layer0    <= 1'b1;
            r_layer     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            r_bound     <= ({2'b00, r_lim} << 1) + {2'b00, r_lim} + BW'(1);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_lim   <= lim_cl;
                        r_clr   <= '0;
                        r_one   <= COST_NONE;
                        if (i_restart) begin
                            r_layer0 <= 1'b1;
                            r_layer  <= '0;
                        end
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LAST_ADDR) begin
                        r_x     <= AW'(1);
                        r_x9    <= 4'd1;
                        r_q     <= '0;
                        r_state <= (r_lim == '0) ? S_DONE : S_RDCUR;
                    end
                end
                S_RDCUR: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (cur_c == COST_NONE) begin
                        if (x_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_x     <= r_x + AW'(1);
                            r_x9    <= (r_x9 == 4'd8) ? 4'd0 : r_x9 + 4'd1;
                            r_q     <= (m == 2'd2) ? r_q + AW'(1) : r_q;
                            r_state <= S_RDCUR;
                        end
                    end else begin
                        r_c     <= cur_c;
                        r_k     <= k0;
                        r_t     <= t0;
                        r_y     <= y0;
                        r_r     <= r0;
                        r_ym    <= ym0;
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    if (move_end) begin
                        if (x_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_x     <= r_x + AW'(1);
                            r_x9    <= (r_x9 == 4'd8) ? 4'd0 : r_x9 + 4'd1;
                            r_q     <= (m == 2'd2) ? r_q + AW'(1) : r_q;
                            r_state <= S_RDCUR;
                        end
                    end else if (r_ym == 2'd0) begin
                        // target is a multiple of three: skip the move
                        r_k  <= r_k + KW'(2);
                        r_t  <= r_t << 2;
                        r_y  <= y_step;
                        r_ym <= ym_step;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (upd_ok && (r_y == AW'(1))) begin
                        r_one <= tot[COST_W-1:0];
                    end
                    r_k     <= r_k + KW'(2);
                    r_t     <= r_t << 2;
                    r_y     <= y_step;
                    r_ym    <= ym_step;
                    r_state <= S_MOVE;
                end
                S_DONE: begin
                    r_res_valid        <= 1'b1;
                    r_res.layer_number <= layer_inc;
                    r_res.found        <= (r_one != COST_NONE);
                    r_res.min_cost     <= (r_one != COST_NONE) ? r_one : '0;
                    r_layer            <= layer_inc;
                    r_bank_sel         <= ~r_bank_sel;
                    r_layer0           <= 1'b0;
                    r_state            <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_bank_sel  = r_bank_sel;
    assign o_cur_raddr = r_x;
    assign o_nxt_raddr = r_y;
    assign o_nxt_we    = (r_state == S_CLEAR) || ((r_state == S_UPD) && upd_ok);
    assign o_nxt_waddr = (r_state == S_CLEAR) ? r_clr : r_y;
    assign o_nxt_wdata = (r_state == S_CLEAR) ? COST_NONE : tot[COST_W-1:0];
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

[hw/rtl/reverse_collatz_layer_min_plus_dp.sv]
// Top level: layer stores, bank routing, limit register and sequencer.
//
//   channel   handshake                      payload
//   command   start / busy (taken: start&!busy) i_restart
//   result    o_valid, one-cycle strobe      o_layer_number, o_found, o_min_cost
//   config    i_cfg_valid / o_cfg_ready      i_cfg_data (value limit)
//
// Per word: clear the whole next store, read and check each swept value, try each
// move and update the next store on a legal move, end each reached value, then
// finish. The single read and write port of each store paces these steps.
// Reset is synchronous; layer zero is flagged, so no clearing pass follows reset.
// busy stays high for the whole layer; results cannot be held off.
`default_nettype none

module reverse_collatz_layer_min_plus_dp import rclmp_pkg::*; #(
    parameter int STORE_DEPTH = DEPTH_DEF,
    parameter int MAX_SHIFT   = MAX_SHIFT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_restart,
    output logic             o_valid,
    output logic [15:0]      o_layer_number,
    output logic             o_found,
    output logic [15:0]      o_min_cost,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [15:0]       r_value_limit;
    logic              bank_sel;
    logic [AW-1:0]     cur_raddr;
    logic [COST_W-1:0] cur_rdata;
    logic [AW-1:0]     nxt_raddr;
    logic              nxt_we;
    logic [AW-1:0]     nxt_waddr;
    logic [COST_W-1:0] nxt_wdata;
    logic [COST_W-1:0] nxt_rdata;
    logic [COST_W-1:0] a_rdata;
    logic [COST_W-1:0] b_rdata;
    logic              res_valid;
    t_result           res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_value_limit <= i_cfg_data;
        end
    end

    rclmp_seq #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_SHIFT   (MAX_SHIFT)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_restart     (i_restart),
        .i_value_limit (r_value_limit),
        .o_busy        (busy),
        .o_bank_sel    (bank_sel),
        .o_cur_raddr   (cur_raddr),
        .i_cur_rdata   (cur_rdata),
        .o_nxt_raddr   (nxt_raddr),
        .o_nxt_we      (nxt_we),
        .o_nxt_waddr   (nxt_waddr),
        .o_nxt_wdata   (nxt_wdata),
        .i_nxt_rdata   (nxt_rdata),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // bank_sel low: store a is current, store b is next
    rclmp_bank #(
        .DEPTH (STORE_DEPTH)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (bank_sel & nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (bank_sel ? nxt_raddr : cur_raddr),
        .o_rdata (a_rdata)
    );

    rclmp_bank #(
        .DEPTH (STORE_DEPTH)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (~bank_sel & nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (bank_sel ? cur_raddr : nxt_raddr),
        .o_rdata (b_rdata)
    );

    assign cur_rdata = bank_sel ? b_rdata : a_rdata;
    assign nxt_rdata = bank_sel ? a_rdata : b_rdata;

    assign o_valid        = res_valid;
    assign o_layer_number = res.layer_number;
    assign o_found        = res.found;
    assign o_min_cost     = res.min_cost;

endmodule

`default_nettype wire

[hw/rtl/rclmp_chk.sv]
// Port-level checks for the layer engine, bound to the top level.
`default_nettype none

module rclmp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic        o_found,
    input wire logic [15:0] o_min_cost
);

    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command word did not raise busy");

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("layer finished without a result word");

    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word shown while still busy");

    a_cost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_min_cost == 16'd0)
        else $error("nonzero cost on a not-found result");

endmodule

bind reverse_collatz_layer_min_plus_dp rclmp_chk u_rclmp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_found    (o_found),
    .o_min_cost (o_min_cost)
);

`default_nettype wire
